>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Antecedent implies consequent a fixed number of cycles later.
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("latency check failed");

// Expression never true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

>>> src/a64d_pkg.sv
// Shared types, codes and encoding masks for the A64 decoder.
`timescale 1ns / 1ps
package a64d_pkg;

    localparam int QUEUE_DEPTH = 2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNSUP   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // operation codes
    localparam logic [4:0] OP_ADRP = 5'd0;
    localparam logic [4:0] OP_ADR  = 5'd1;
    localparam logic [4:0] OP_ADD  = 5'd2;
    localparam logic [4:0] OP_AND  = 5'd6;
    localparam logic [4:0] OP_MOVN = 5'd10;
    localparam logic [4:0] OP_MOVZ = 5'd11;
    localparam logic [4:0] OP_MOVK = 5'd12;
    localparam logic [4:0] OP_SBFM = 5'd13;
    localparam logic [4:0] OP_EXT  = 5'd16;

    // opc field values
    localparam logic [1:0] OPC_0 = 2'd0;
    localparam logic [1:0] OPC_1 = 2'd1;
    localparam logic [1:0] OPC_2 = 2'd2;
    localparam logic [1:0] OPC_3 = 2'd3;

    // subclass found by the front end
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_ADR     = 3'd0;
    localparam t_kind KIND_ADDSUB  = 3'd1;
    localparam t_kind KIND_LOGIC   = 3'd2;
    localparam t_kind KIND_MOVW    = 3'd3;
    localparam t_kind KIND_BITF    = 3'd4;
    localparam t_kind KIND_EXTR    = 3'd5;
    localparam t_kind KIND_UNSUP   = 3'd6;
    localparam t_kind KIND_INVALID = 3'd7;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] word;
    } t_qent;

    // top-level groups
    localparam logic [31:0] M_GRP_DPI  = 32'h1C00_0000;
    localparam logic [31:0] V_GRP_DPI  = 32'h1000_0000;
    localparam logic [31:0] V_GRP_BRS  = 32'h1400_0000;
    localparam logic [31:0] M_GRP_LDST = 32'h0A00_0000;
    localparam logic [31:0] V_GRP_LDST = 32'h0800_0000;
    localparam logic [31:0] M_GRP_DPR  = 32'h0E00_0000;
    localparam logic [31:0] V_GRP_DPR  = 32'h0A00_0000;
    localparam logic [31:0] V_GRP_SIMD = 32'h0E00_0000;

    // data processing immediate subclasses
    localparam logic [31:0] M_DPI_A = 32'h1F00_0000;
    localparam logic [31:0] M_DPI_B = 32'h1F80_0000;
    localparam logic [31:0] V_ADR   = 32'h1000_0000;
    localparam logic [31:0] V_ADDS  = 32'h1100_0000;
    localparam logic [31:0] V_LOGI  = 32'h1200_0000;
    localparam logic [31:0] V_MOVW  = 32'h1280_0000;
    localparam logic [31:0] V_BITF  = 32'h1300_0000;
    localparam logic [31:0] V_EXTR  = 32'h1380_0000;

    function automatic logic hit(input logic [31:0] w, input logic [31:0] m,
                                 input logic [31:0] v);
        hit = (w & m) == v;
    endfunction

    function automatic logic brs_known(input logic [31:0] w);
        brs_known = hit(w, 32'h7C00_0000, 32'h1400_0000) ||
                    hit(w, 32'h7E00_0000, 32'h3400_0000) ||
                    hit(w, 32'h7E00_0000, 32'h3600_0000) ||
                    hit(w, 32'hFE00_0000, 32'h5400_0000) ||
                    hit(w, 32'hFF00_0000, 32'hD400_0000) ||
                    hit(w, 32'hFFC0_0000, 32'hD500_0000) ||
                    hit(w, 32'hFE00_0000, 32'hD600_0000);
    endfunction

    function automatic logic dpr_known(input logic [31:0] w);
        dpr_known = hit(w, 32'h1F00_0000, 32'h0A00_0000) ||
                    hit(w, 32'h1F20_0000, 32'h0B00_0000) ||
                    hit(w, 32'h1F20_0000, 32'h0B20_0000) ||
                    hit(w, 32'h1FE0_0000, 32'h1A00_0000) ||
                    hit(w, 32'h1FE0_0800, 32'h1A40_0000) ||
                    hit(w, 32'h1FE0_0800, 32'h1A40_0800) ||
                    hit(w, 32'h1FE0_0000, 32'h1A80_0000) ||
                    hit(w, 32'h1F00_0000, 32'h1B00_0000) ||
                    hit(w, 32'h5FE0_0000, 32'h1AC0_0000) ||
                    hit(w, 32'h5FE0_0000, 32'h5AC0_0000);
    endfunction

endpackage

>>> src/a64d_front.sv
// Front end: takes instruction words and tags each with its subclass.
`timescale 1ns / 1ps
module a64d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_word,
    input  logic             i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output a64d_pkg::t_qent  o_ent
);
    logic            r_valid, n_valid;
    a64d_pkg::t_qent r_ent;
    a64d_pkg::t_kind n_kind;
    logic            accept;

    always_comb begin
        if (a64d_pkg::hit(i_word, a64d_pkg::M_GRP_DPI, a64d_pkg::V_GRP_DPI)) begin
            if (a64d_pkg::hit(i_word, a64d_pkg::M_DPI_A, a64d_pkg::V_ADR))
                n_kind = a64d_pkg::KIND_ADR;
            else if (a64d_pkg::hit(i_word, a64d_pkg::M_DPI_A, a64d_pkg::V_ADDS))
                n_kind = a64d_pkg::KIND_ADDSUB;
            else if (a64d_pkg::hit(i_word, a64d_pkg::M_DPI_B, a64d_pkg::V_LOGI))
                n_kind = a64d_pkg::KIND_LOGIC;
            else if (a64d_pkg::hit(i_word, a64d_pkg::M_DPI_B, a64d_pkg::V_MOVW))
                n_kind = a64d_pkg::KIND_MOVW;
            else if (a64d_pkg::hit(i_word, a64d_pkg::M_DPI_B, a64d_pkg::V_BITF))
                n_kind = a64d_pkg::KIND_BITF;
            else if (a64d_pkg::hit(i_word, a64d_pkg::M_DPI_B, a64d_pkg::V_EXTR))
                n_kind = a64d_pkg::KIND_EXTR;
            else
                n_kind = a64d_pkg::KIND_INVALID;
        end else if (a64d_pkg::hit(i_word, a64d_pkg::M_GRP_DPI, a64d_pkg::V_GRP_BRS)) begin
            n_kind = a64d_pkg::brs_known(i_word) ? a64d_pkg::KIND_UNSUP
                                                 : a64d_pkg::KIND_INVALID;
        end else if (a64d_pkg::hit(i_word, a64d_pkg::M_GRP_LDST, a64d_pkg::V_GRP_LDST)) begin
            n_kind = a64d_pkg::KIND_UNSUP;
        end else if (a64d_pkg::hit(i_word, a64d_pkg::M_GRP_DPR, a64d_pkg::V_GRP_DPR)) begin
            n_kind = a64d_pkg::dpr_known(i_word) ? a64d_pkg::KIND_UNSUP
                                                 : a64d_pkg::KIND_INVALID;
        end else if (a64d_pkg::hit(i_word, a64d_pkg::M_GRP_DPR, a64d_pkg::V_GRP_SIMD)) begin
            n_kind = a64d_pkg::KIND_UNSUP;
        end else begin
            n_kind = a64d_pkg::KIND_INVALID;
        end
    end

    assign o_push  = r_valid && !i_q_full;
    assign o_ready = i_rst_n && (!r_valid || !i_q_full);
    assign accept  = i_start && o_ready;
    assign o_ent   = r_ent;

    always_comb begin
        n_valid = r_valid;
        if (accept)
            n_valid = 1'b1;
        else if (o_push)
            n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent.kind <= n_kind;
            r_ent.word <= i_word;
        end
    end

endmodule

>>> src/a64d_queue.sv
// Small FIFO between the classify and decode stages.
`timescale 1ns / 1ps
module a64d_queue #(
    parameter int DEPTH = a64d_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  a64d_pkg::t_qent  i_ent,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output a64d_pkg::t_qent  o_ent
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    a64d_pkg::t_qent r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_ent   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push)
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        if (do_pop)
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        if (do_push && !do_pop)
            n_count = r_count + 1'b1;
        else if (do_pop && !do_push)
            n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr_ptr] <= i_ent;
    end

endmodule

>>> src/a64d_back.sv
// Back end: field extraction and registered decode record.
`timescale 1ns / 1ps
module a64d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  a64d_pkg::t_qent  i_ent,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [4:0]       o_operation,
    output logic             o_wide,
    output logic [4:0]       o_dest_reg,
    output logic [4:0]       o_first_src_reg,
    output logic [4:0]       o_second_src_reg,
    output logic [20:0]      o_immediate,
    output logic [1:0]       o_shift_amount,
    output logic [5:0]       o_imms_field,
    output logic [5:0]       o_immr_field
);
    logic        r_valid;
    logic [1:0]  r_status, n_status;
    logic [4:0]  r_op, n_op;
    logic        r_wide, n_wide;
    logic [4:0]  r_rd, n_rd;
    logic [4:0]  r_rn, n_rn;
    logic [4:0]  r_rm, n_rm;
    logic [20:0] r_imm, n_imm;
    logic [1:0]  r_shift, n_shift;
    logic [5:0]  r_imms, n_imms;
    logic [5:0]  r_immr, n_immr;
    logic [31:0] w;
    logic [1:0]  opc;

    assign w   = i_ent.word;
    assign opc = w[30:29];

    always_comb begin
        n_status = a64d_pkg::ST_OK;
        n_op     = '0;
        n_wide   = w[31];
        n_rd     = w[4:0];
        n_rn     = w[9:5];
        n_rm     = '0;
        n_imm    = '0;
        n_shift  = '0;
        n_imms   = '0;
        n_immr   = '0;
        unique case (i_ent.kind)
            a64d_pkg::KIND_ADR: begin
                n_op   = w[31] ? a64d_pkg::OP_ADRP : a64d_pkg::OP_ADR;
                n_wide = 1'b1;
                n_rn   = '0;
                n_imm  = {w[23:5], opc};
            end
            a64d_pkg::KIND_ADDSUB: begin
                n_op    = a64d_pkg::OP_ADD + {3'b000, opc};
                n_imm   = {9'd0, w[21:10]};
                n_shift = w[23:22];
            end
            a64d_pkg::KIND_LOGIC: begin
                n_op   = a64d_pkg::OP_AND + {3'b000, opc};
                n_imms = w[15:10];
                n_immr = w[21:16];
            end
            a64d_pkg::KIND_MOVW: begin
                case (opc)
                    a64d_pkg::OPC_0: n_op = a64d_pkg::OP_MOVN;
                    a64d_pkg::OPC_2: n_op = a64d_pkg::OP_MOVZ;
                    a64d_pkg::OPC_3: n_op = a64d_pkg::OP_MOVK;
                    default:         n_status = a64d_pkg::ST_INVALID;
                endcase
                n_rn    = '0;
                n_imm   = {5'd0, w[20:5]};
                n_shift = w[22:21];
            end
            a64d_pkg::KIND_BITF: begin
                if (opc == a64d_pkg::OPC_3)
                    n_status = a64d_pkg::ST_INVALID;
                n_op   = a64d_pkg::OP_SBFM + {3'b000, opc};
                n_imms = w[15:10];
                n_immr = w[21:16];
            end
            a64d_pkg::KIND_EXTR: begin
                if (opc != a64d_pkg::OPC_0)
                    n_status = a64d_pkg::ST_INVALID;
                n_op   = a64d_pkg::OP_EXT;
                n_rm   = w[20:16];
                n_imms = w[15:10];
            end
            a64d_pkg::KIND_UNSUP:   n_status = a64d_pkg::ST_UNSUP;
            a64d_pkg::KIND_INVALID: n_status = a64d_pkg::ST_INVALID;
            default:                n_status = a64d_pkg::ST_INVALID;
        endcase
        // anything not decoded reports an all-zero record
        if (n_status != a64d_pkg::ST_OK) begin
            n_op    = '0;
            n_wide  = 1'b0;
            n_rd    = '0;
            n_rn    = '0;
            n_rm    = '0;
            n_imm   = '0;
            n_shift = '0;
            n_imms  = '0;
            n_immr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_status <= n_status;
            r_op     <= n_op;
            r_wide   <= n_wide;
            r_rd     <= n_rd;
            r_rn     <= n_rn;
            r_rm     <= n_rm;
            r_imm    <= n_imm;
            r_shift  <= n_shift;
            r_imms   <= n_imms;
            r_immr   <= n_immr;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_operation      = r_op;
    assign o_wide           = r_wide;
    assign o_dest_reg       = r_rd;
    assign o_first_src_reg  = r_rn;
    assign o_second_src_reg = r_rm;
    assign o_immediate      = r_imm;
    assign o_shift_amount   = r_shift;
    assign o_imms_field     = r_imms;
    assign o_immr_field     = r_immr;

endmodule

>>> src/a64_instruction_decoder.sv
// Top level of the A64 instruction decoder.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  command   | start / busy       | i_instruction_word
//  result    | o_valid (strobe)   | o_status .. o_immr_field
//
// One instruction per cycle sustained; a result strobes once its command transaction
// has passed the classify register, a FIFO slot and the decode output register.
// The decode stage drains the FIFO every cycle, so busy stays low except
// while i_rst_n is held low. Synchronous active-low reset empties all stages.
// The result port has no stall; each record is shown for exactly one cycle.
`timescale 1ns / 1ps
module a64_instruction_decoder #(
    parameter int QUEUE_DEPTH = a64d_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_instruction_word,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [4:0]  o_operation,
    output logic        o_wide,
    output logic [4:0]  o_dest_reg,
    output logic [4:0]  o_first_src_reg,
    output logic [4:0]  o_second_src_reg,
    output logic [20:0] o_immediate,
    output logic [1:0]  o_shift_amount,
    output logic [5:0]  o_imms_field,
    output logic [5:0]  o_immr_field
);
    logic            front_ready;
    logic            push;
    a64d_pkg::t_qent push_ent;
    logic            q_full;
    logic            q_valid;
    a64d_pkg::t_qent q_ent;

    assign busy = !front_ready;

    a64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_word  (i_instruction_word),
        .i_q_full(q_full),
        .o_ready (front_ready),
        .o_push  (push),
        .o_ent   (push_ent)
    );

    a64d_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_ent  (push_ent),
        .i_pop  (q_valid),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_ent  (q_ent)
    );

    a64d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_ent           (q_ent),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_operation     (o_operation),
        .o_wide          (o_wide),
        .o_dest_reg      (o_dest_reg),
        .o_first_src_reg (o_first_src_reg),
        .o_second_src_reg(o_second_src_reg),
        .o_immediate     (o_immediate),
        .o_shift_amount  (o_shift_amount),
        .o_imms_field    (o_imms_field),
        .o_immr_field    (o_immr_field)
    );

endmodule

>>> src/a64d_checker.sv
// Port-level checks for the A64 decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module a64d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [4:0]  o_operation,
    input logic        o_wide,
    input logic [4:0]  o_dest_reg,
    input logic [4:0]  o_first_src_reg,
    input logic [4:0]  o_second_src_reg,
    input logic [20:0] o_immediate,
    input logic [1:0]  o_shift_amount,
    input logic [5:0]  o_imms_field,
    input logic [5:0]  o_immr_field
);
    logic rec_zero;

    assign rec_zero = o_operation == '0 && !o_wide && o_dest_reg == '0 &&
                      o_first_src_reg == '0 && o_second_src_reg == '0 &&
                      o_immediate == '0 && o_shift_amount == '0 &&
                      o_imms_field == '0 && o_immr_field == '0;

    `ASSERT_NEVER(a_no_busy, i_clk, i_rst_n, busy)
    `ASSERT_DELAY(a_latency, i_clk, i_rst_n, start && !busy, 3, o_valid)
    `ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, o_valid, o_status <= a64d_pkg::ST_INVALID)
    `ASSERT_IMPLY(a_zero_record, i_clk, i_rst_n, o_valid && o_status != a64d_pkg::ST_OK, rec_zero)
endmodule

bind a64_instruction_decoder a64d_checker u_a64d_checker (.*);
